FILE: src/sctc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sctc_pkg;

  // Console geometry.
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;

  // Field widths.
  localparam int SCAN_W = 8;
  localparam int CHAR_W = 7;
  localparam int ATTR_W = 8;
  localparam int CUR_W  = 11;
  localparam int COL_W  = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
  // Wide enough for the cursor plus one full row.
  localparam int CUR_EXT_W = CUR_W + 1;
  // Wide enough for the cell count at the largest geometry.
  localparam int CMP_W = 16;

  // Command queue between the classifier and the cursor engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QPTR_W-1:0] QUEUE_LAST = QPTR_W'(QUEUE_DEPTH - 1);

  // Cursor arithmetic constants.
  localparam logic [CMP_W-1:0] CELLS_CMP   = CMP_W'(SCREEN_CELLS);
  localparam logic [COL_W:0]   COLS_EXT    = (COL_W + 1)'(SCREEN_COLUMNS);
  localparam logic [COL_W-1:0] LAST_COL    = COL_W'(SCREEN_COLUMNS - 1);
  // Column of a row start that lands past the 11-bit cursor range.
  localparam logic [COL_W-1:0] OVER_COL    =
    COL_W'((SCREEN_COLUMNS - ((1 << CUR_W) % SCREEN_COLUMNS)) % SCREEN_COLUMNS);

  // Scancode and key codes.
  localparam logic [SCAN_W-1:0] PREFIX_BYTE   = 8'hE0;
  localparam logic [CHAR_W-1:0] KEY_NONE      = 7'h00;
  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 7'h08;
  localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 7'h0A;
  localparam logic [CHAR_W-1:0] KEY_SPACE     = 7'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // Operation handed from the classifier to the cursor engine.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_CHAR,
    OP_NEWLINE,
    OP_BACKSPACE
  } sctc_op_t;

  typedef struct packed {
    sctc_op_t          op;
    logic [CHAR_W-1:0] ch;
  } sctc_cmd_t;

  // Handshake between queue and its neighbors.
  typedef struct packed {
    logic valid;
    logic ready;
  } sctc_hs_t;

  // Set 1 make code to ASCII; zero means the key is ignored.
  function automatic logic [CHAR_W-1:0] key_lookup(input logic [6:0] code);
    logic [CHAR_W-1:0] k;
    unique case (code)
      7'h01: k = 7'h1B;
      7'h02: k = 7'h31;
      7'h03: k = 7'h32;
      7'h04: k = 7'h33;
      7'h05: k = 7'h34;
      7'h06: k = 7'h35;
      7'h07: k = 7'h36;
      7'h08: k = 7'h37;
      7'h09: k = 7'h38;
      7'h0A: k = 7'h39;
      7'h0B: k = 7'h30;
      7'h0C: k = 7'h2D;
      7'h0D: k = 7'h3D;
      7'h0E: k = 7'h08;
      7'h0F: k = 7'h09;
      7'h10: k = 7'h71;
      7'h11: k = 7'h77;
      7'h12: k = 7'h65;
      7'h13: k = 7'h72;
      7'h14: k = 7'h74;
      7'h15: k = 7'h79;
      7'h16: k = 7'h75;
      7'h17: k = 7'h69;
      7'h18: k = 7'h6F;
      7'h19: k = 7'h70;
      7'h1A: k = 7'h5B;
      7'h1B: k = 7'h5D;
      7'h1C: k = 7'h0A;
      7'h1E: k = 7'h61;
      7'h1F: k = 7'h73;
      7'h20: k = 7'h64;
      7'h21: k = 7'h66;
      7'h22: k = 7'h67;
      7'h23: k = 7'h68;
      7'h24: k = 7'h6A;
      7'h25: k = 7'h6B;
      7'h26: k = 7'h6C;
      7'h27: k = 7'h3B;
      7'h28: k = 7'h27;
      7'h29: k = 7'h60;
      7'h2B: k = 7'h5C;
      7'h2C: k = 7'h7A;
      7'h2D: k = 7'h78;
      7'h2E: k = 7'h63;
      7'h2F: k = 7'h76;
      7'h30: k = 7'h62;
      7'h31: k = 7'h6E;
      7'h32: k = 7'h6D;
      7'h33: k = 7'h2C;
      7'h34: k = 7'h2E;
      7'h35: k = 7'h2F;
      7'h37: k = 7'h2A;
      7'h39: k = 7'h20;
      7'h47: k = 7'h37;
      7'h48: k = 7'h38;
      7'h49: k = 7'h39;
      7'h4A: k = 7'h2D;
      7'h4B: k = 7'h34;
      7'h4C: k = 7'h35;
      7'h4D: k = 7'h36;
      7'h4E: k = 7'h2B;
      7'h4F: k = 7'h31;
      7'h50: k = 7'h32;
      7'h51: k = 7'h33;
      7'h52: k = 7'h30;
      7'h53: k = 7'h2E;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: src/sctc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sctc_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [sctc_pkg::SCAN_W-1:0] in_scan_byte,
  output sctc_pkg::sctc_hs_t             push_hs,
  input  wire logic                      push_ready,
  output sctc_pkg::sctc_cmd_t            push_cmd
);
  import sctc_pkg::*;

  logic              ext_r;
  logic              ext_nxt;
  logic              push;
  logic [CHAR_W-1:0] key;

  // The queue takes a transaction whenever it has room.
  assign in_stall      = !push_ready;
  assign push          = in_valid && push_ready;
  assign push_hs.valid = push;
  assign push_hs.ready = push_ready;

  assign key = key_lookup(in_scan_byte[6:0]);

  // Classify the byte and track the extended prefix.
  always_comb begin
    ext_nxt      = ext_r;
    push_cmd.op  = OP_NONE;
    push_cmd.ch  = key;
    priority if (in_scan_byte == PREFIX_BYTE) begin
      ext_nxt = 1'b1;
    end else if (in_scan_byte[SCAN_W-1]) begin
      ext_nxt = 1'b0;
    end else if (ext_r) begin
      ext_nxt = 1'b0;
    end else if (key == KEY_NEWLINE) begin
      push_cmd.op = OP_NEWLINE;
    end else if (key == KEY_BACKSPACE) begin
      push_cmd.op = OP_BACKSPACE;
    end else if (key != KEY_NONE) begin
      push_cmd.op = OP_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= 1'b0;
    end else if (push) begin
      ext_r <= ext_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/sctc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sctc_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sctc_pkg::sctc_hs_t  push_hs,
  input  wire sctc_pkg::sctc_cmd_t push_cmd,
  output logic                     push_ready,
  output logic                     head_valid,
  output sctc_pkg::sctc_cmd_t      head_cmd,
  input  wire logic                pop
);
  import sctc_pkg::*;

  sctc_cmd_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  // Occupancy after this cycle's push and pop.
  always_comb begin
    count_nxt = count_r;
    unique case ({push_hs.valid, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_hs.valid) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_hs.valid) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_LAST) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_LAST) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // A full queue must never be written, nor an empty one read.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_hs.valid |-> push_hs.ready)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");

  // Pointers stay one occupancy apart.
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == QCNT_W'(1)) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with occupancy");

endmodule

`default_nettype wire

FILE: src/sctc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sctc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          head_valid,
  input  wire sctc_pkg::sctc_cmd_t           head_cmd,
  output logic                               pop,
  input  wire logic [sctc_pkg::ATTR_W-1:0]   attribute,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_write_valid,
  output logic [sctc_pkg::CUR_W-1:0]         out_cell_index,
  output logic [sctc_pkg::CHAR_W-1:0]        out_char_code,
  output logic [sctc_pkg::ATTR_W-1:0]        out_cell_attribute,
  output logic [sctc_pkg::CUR_W-1:0]         out_cursor_after
);
  import sctc_pkg::*;

  logic                 out_valid_r;
  logic                 write_r;
  logic                 write_nxt;
  logic [CUR_W-1:0]     cell_r;
  logic [CUR_W-1:0]     cell_nxt;
  logic [CHAR_W-1:0]    char_r;
  logic [CHAR_W-1:0]    char_nxt;
  logic [ATTR_W-1:0]    attr_r;
  logic [ATTR_W-1:0]    attr_nxt;
  logic [CUR_W-1:0]     cursor_r;
  logic [CUR_W-1:0]     cursor_nxt;
  logic [COL_W-1:0]     col_r;
  logic [COL_W-1:0]     col_nxt;
  logic [CUR_EXT_W-1:0] row_next;
  logic [CUR_EXT_W-1:0] step_next;
  logic [COL_W:0]       col_inc;

  // The output register is free when empty or being drained.
  assign pop = head_valid && (!out_valid_r || !out_stall);

  assign row_next  = CUR_EXT_W'(cursor_r) + CUR_EXT_W'(COLS_EXT - {1'b0, col_r});
  assign step_next = CUR_EXT_W'(cursor_r) + CUR_EXT_W'(1);
  assign col_inc   = {1'b0, col_r} + (COL_W + 1)'(1);

  // Cursor engine: the column is tracked alongside the linear index.
  always_comb begin
    write_nxt  = 1'b0;
    cell_nxt   = '0;
    char_nxt   = '0;
    attr_nxt   = '0;
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    unique case (head_cmd.op)
      OP_NEWLINE: begin
        if (CMP_W'(row_next) >= CELLS_CMP) begin
          cursor_nxt = '0;
          col_nxt    = '0;
        end else if (row_next[CUR_W]) begin
          cursor_nxt = row_next[CUR_W-1:0];
          col_nxt    = OVER_COL;
        end else begin
          cursor_nxt = row_next[CUR_W-1:0];
          col_nxt    = '0;
        end
      end
      OP_BACKSPACE: begin
        if (cursor_r != '0) begin
          write_nxt  = 1'b1;
          cursor_nxt = cursor_r - CUR_W'(1);
          cell_nxt   = cursor_r - CUR_W'(1);
          char_nxt   = KEY_SPACE;
          attr_nxt   = attribute;
          col_nxt    = (col_r == '0) ? LAST_COL : col_r - COL_W'(1);
        end
      end
      OP_CHAR: begin
        write_nxt = 1'b1;
        cell_nxt  = cursor_r;
        char_nxt  = head_cmd.ch;
        attr_nxt  = attribute;
        if ((CMP_W'(step_next) >= CELLS_CMP) || step_next[CUR_W]) begin
          cursor_nxt = '0;
          col_nxt    = '0;
        end else begin
          cursor_nxt = step_next[CUR_W-1:0];
          col_nxt    = (col_inc == COLS_EXT) ? '0 : col_inc[COL_W-1:0];
        end
      end
      default: begin
        cursor_nxt = cursor_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cursor_r    <= '0;
      col_r       <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        cursor_r    <= cursor_nxt;
        col_r       <= col_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      write_r <= write_nxt;
      cell_r  <= cell_nxt;
      char_r  <= char_nxt;
      attr_r  <= attr_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_write_valid    = write_r;
  assign out_cell_index     = cell_r;
  assign out_char_code      = char_r;
  assign out_cell_attribute = attr_r;
  assign out_cursor_after   = cursor_r;

  // The cursor stays on the screen and the column tracks it.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cursor_r) < CELLS_CMP)
    else $error("cursor beyond screen");

  a_col_match: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(col_r) < SCREEN_COLUMNS) && ((cursor_r != '0) || (col_r == '0)))
    else $error("column out of step with cursor");

  // A written cell is always the cursor cell or the one before it.
  a_cell_near: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && write_r) |-> (cell_r != cursor_r || char_r == KEY_SPACE))
    else $error("written cell inconsistent with cursor");

endmodule

`default_nettype wire

FILE: src/scancode_to_text_console_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Set 1 scancode to text console. Each accepted scancode byte yields exactly
// one result: an optional cell write (index, ASCII code, attribute) and the
// cursor position after the byte. The 0xE0 prefix, release codes, extended
// presses and unmapped keys leave the cell write empty and report the cursor.
// A byte can be accepted every clock cycle while in_stall is low, that is
// while the two-entry command queue between the classifier and the cursor
// engine has room. The cursor engine takes each command from the queue and
// loads its result into the output register behind it, where the result is
// held while the output is stalled. The console is 80 by 25 cells by
// default and the cursor wraps to zero past the last cell. The attribute
// register resets to 0x0F and should be written only while no transaction
// is in flight.
module scancode_to_text_console_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sctc_pkg::SCAN_W-1:0]   in_scan_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_write_valid,
  output logic [sctc_pkg::CUR_W-1:0]         out_cell_index,
  output logic [sctc_pkg::CHAR_W-1:0]        out_char_code,
  output logic [sctc_pkg::ATTR_W-1:0]        out_cell_attribute,
  output logic [sctc_pkg::CUR_W-1:0]         out_cursor_after,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sctc_pkg::ATTR_W-1:0]   cfg_text_attribute
);
  import sctc_pkg::*;

  logic [ATTR_W-1:0] attr_r;
  sctc_hs_t          push_hs;
  sctc_cmd_t         push_cmd;
  logic              push_ready;
  logic              head_valid;
  sctc_cmd_t         head_cmd;
  logic              pop;

  // Attribute register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr_r <= cfg_text_attribute;
    end
  end

  sctc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_scan_byte (in_scan_byte),
    .push_hs      (push_hs),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  sctc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_hs    (push_hs),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  sctc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_cmd           (head_cmd),
    .pop                (pop),
    .attribute          (attr_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_write_valid    (out_write_valid),
    .out_cell_index     (out_cell_index),
    .out_char_code      (out_char_code),
    .out_cell_attribute (out_cell_attribute),
    .out_cursor_after   (out_cursor_after)
  );

endmodule

`default_nettype wire
